FILE: hw/rtl/box_overlap_stability_check_defines.svh
// assertion macros used by the checker of the box overlap stability check
`ifndef BOX_OVERLAP_STABILITY_CHECK_DEFINES_SVH
`define BOX_OVERLAP_STABILITY_CHECK_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define BOS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define BOS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/bos_pkg.sv
// shared widths, reset values, register indexes and state codes of the box overlap check
package bos_pkg;

  // field widths
  localparam int unsigned BoxW   = 16;
  localparam int unsigned ThrW   = 16;
  localparam int unsigned RunW   = 8;
  localparam int unsigned AreaW  = 2 * BoxW;
  localparam int unsigned SumW   = AreaW + 1;
  localparam int unsigned ProdW  = ThrW + SumW;
  localparam int unsigned EdgeW  = BoxW + 1;
  localparam int unsigned CfgW   = ThrW;

  // 2 * 1.0 in q1.15 is a plain left shift
  localparam int unsigned ScaleShift = 16;

  // shift-add multiplier steps, one multiplier bit per cycle
  localparam int unsigned MulSteps = 16;
  localparam int unsigned CntW     = $clog2(MulSteps);
  localparam logic [CntW-1:0] LastCnt = CntW'(MulSteps - 1);

  // register reset values
  localparam logic [ThrW-1:0] ThrReset = 16'd26214;
  localparam logic [RunW-1:0] MinReset = 8'd5;
  localparam logic [RunW-1:0] RunMax   = 8'd255;

  // configuration register indexes
  localparam logic CfgMinOverlap = 1'b0;
  localparam logic CfgMinStable  = 1'b1;

  // sequencer states
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPrep = 5'b00010,
    StMul  = 5'b00100,
    StRat  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

endpackage

FILE: hw/rtl/bos_mul16.sv
// 16 x 16 unsigned shift-add multiplier, one multiplier bit per cycle
module bos_mul16 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bos_pkg::BoxW-1:0]   a_i,
  input  logic [bos_pkg::BoxW-1:0]   b_i,
  output logic                       done_o,
  output logic [bos_pkg::AreaW-1:0]  prod_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [bos_pkg::CntW-1:0]     cnt_q;
  logic [bos_pkg::BoxW-1:0]     a_q;
  logic [bos_pkg::AreaW-1:0]    p_q, p_d;
  logic [bos_pkg::BoxW:0]       sum;

  // add the multiplicand into the upper half when the low bit is set, then shift right
  always_comb begin
    sum = {1'b0, p_q[bos_pkg::AreaW-1:bos_pkg::BoxW]}
        + (p_q[0] ? {1'b0, a_q} : '0);
    p_d = {sum, p_q[bos_pkg::BoxW-1:1]};
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == bos_pkg::LastCnt);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == bos_pkg::LastCnt) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // operand and partial product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{bos_pkg::BoxW{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

FILE: hw/rtl/bos_ratio_chk.sv
// serial threshold scaling of the area sum and the overlap ratio compare
module bos_ratio_chk (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bos_pkg::ThrW-1:0]   thr_i,
  input  logic [bos_pkg::AreaW-1:0]  area_a_i,
  input  logic [bos_pkg::AreaW-1:0]  area_b_i,
  input  logic [bos_pkg::AreaW-1:0]  inter_i,
  output logic                       done_o,
  output logic                       pass_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [bos_pkg::CntW-1:0]     cnt_q;
  logic [bos_pkg::SumW-1:0]     sum_q;
  logic [bos_pkg::ProdW-1:0]    p_q, p_d;
  logic [bos_pkg::SumW:0]       acc;
  logic [bos_pkg::ProdW-1:0]    lhs;

  // one threshold bit per cycle into the product
  always_comb begin
    acc = {1'b0, p_q[bos_pkg::ProdW-1:bos_pkg::ThrW]}
        + (p_q[0] ? {1'b0, sum_q} : '0);
    p_d = {acc, p_q[bos_pkg::ThrW-1:1]};
  end

  // 2 * inter * 32768, widened to the product width
  assign lhs = {1'b0, inter_i, {bos_pkg::ScaleShift{1'b0}}};

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == bos_pkg::LastCnt);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == bos_pkg::LastCnt) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // area sum and partial product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= {1'b0, area_a_i} + {1'b0, area_b_i};
      p_q   <= {{bos_pkg::SumW{1'b0}}, thr_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  // a zero area sum always fails
  assign done_o = done_q;
  assign pass_o = (sum_q != '0) && (lhs >= p_q);

endmodule

FILE: hw/rtl/box_overlap_stability_check.sv
// Box overlap stability check: one box per beat on the slave stream, one result beat
// (stable flag and run count) per box on the master stream. For an overlapping pair,
// the prepare state first forms the overlap extents. Three 16-step shift-add
// multipliers then run in parallel for the intersection and both areas. A second
// 16-step shift-add pass scales the area sum by the threshold. The run counter is then
// updated as the result is loaded. Disjoint boxes skip the multiplies and the scaling
// pass and go from the prepare state straight to the result. The next box is taken the
// cycle after a result is loaded; a box is not taken while the one before it is still
// being worked on. A finished result waits in the output register, so the next box is
// taken while it is still unread. Configuration writes take effect from the next box
// and are to be made while no box is in flight.
module box_overlap_stability_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // slave stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,   // box_x, box_y, box_w, box_h
  // master stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // stable, run_count, zero pad
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bos_pkg::CfgW-1:0]  cfg_data_i
);

  bos_pkg::state_e state_q, state_d;

  logic [bos_pkg::ThrW-1:0]  thr_q;
  logic [bos_pkg::RunW-1:0]  min_q;
  logic [bos_pkg::RunW-1:0]  run_q, run_next;
  logic                      pass_q;
  logic                      out_valid_q;
  logic                      out_stable_q;
  logic [bos_pkg::RunW-1:0]  out_run_q;

  logic [bos_pkg::BoxW-1:0]  prev_x_q, prev_y_q, prev_w_q, prev_h_q;
  logic [bos_pkg::BoxW-1:0]  new_x_q, new_y_q, new_w_q, new_h_q;

  logic [bos_pkg::EdgeW-1:0] pe_x, pe_y, ne_x, ne_y, lo_x, lo_y, hi_x, hi_y;
  logic [bos_pkg::EdgeW-1:0] dx, dy;
  logic                      disjoint;

  logic                      in_fire, out_load, mul_start, rat_start;
  logic                      inter_done, ap_done, an_done, rat_done, rat_pass;
  logic [bos_pkg::AreaW-1:0] inter, area_p, area_n;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == bos_pkg::StIdle);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= bos_pkg::ThrReset;
      min_q <= bos_pkg::MinReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bos_pkg::CfgMinOverlap: thr_q <= cfg_data_i;
        bos_pkg::CfgMinStable:  min_q <= cfg_data_i[bos_pkg::RunW-1:0];
        default: ;
      endcase
    end
  end

  // incoming box
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      new_x_q <= s_axis_tdata[15:0];
      new_y_q <= s_axis_tdata[31:16];
      new_w_q <= s_axis_tdata[47:32];
      new_h_q <= s_axis_tdata[63:48];
    end
  end

  // far edges, disjoint test and overlap extents
  always_comb begin
    pe_x = {1'b0, prev_x_q} + {1'b0, prev_w_q};
    pe_y = {1'b0, prev_y_q} + {1'b0, prev_h_q};
    ne_x = {1'b0, new_x_q} + {1'b0, new_w_q};
    ne_y = {1'b0, new_y_q} + {1'b0, new_h_q};
    disjoint = ({1'b0, prev_x_q} > ne_x) || ({1'b0, prev_y_q} > ne_y)
            || (pe_x < {1'b0, new_x_q}) || (pe_y < {1'b0, new_y_q});
    hi_x = (pe_x < ne_x) ? pe_x : ne_x;
    hi_y = (pe_y < ne_y) ? pe_y : ne_y;
    lo_x = (prev_x_q > new_x_q) ? {1'b0, prev_x_q} : {1'b0, new_x_q};
    lo_y = (prev_y_q > new_y_q) ? {1'b0, prev_y_q} : {1'b0, new_y_q};
    dx = hi_x - lo_x;
    dy = hi_y - lo_y;
  end

  assign mul_start = (state_q == bos_pkg::StPrep) && !disjoint;
  assign rat_start = (state_q == bos_pkg::StMul) && inter_done;

  // intersection and both areas
  bos_mul16 u_mul_inter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (dx[bos_pkg::BoxW-1:0]),
    .b_i     (dy[bos_pkg::BoxW-1:0]),
    .done_o  (inter_done),
    .prod_o  (inter)
  );

  bos_mul16 u_mul_prev (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (prev_w_q),
    .b_i     (prev_h_q),
    .done_o  (ap_done),
    .prod_o  (area_p)
  );

  bos_mul16 u_mul_new (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (new_w_q),
    .b_i     (new_h_q),
    .done_o  (an_done),
    .prod_o  (area_n)
  );

  // threshold scaling and ratio compare
  bos_ratio_chk u_ratio (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (rat_start),
    .thr_i    (thr_q),
    .area_a_i (area_p),
    .area_b_i (area_n),
    .inter_i  (inter),
    .done_o   (rat_done),
    .pass_o   (rat_pass)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      bos_pkg::StIdle: if (in_fire) state_d = bos_pkg::StPrep;
      bos_pkg::StPrep: state_d = disjoint ? bos_pkg::StOut : bos_pkg::StMul;
      bos_pkg::StMul:  if (inter_done && ap_done && an_done) state_d = bos_pkg::StRat;
      bos_pkg::StRat:  if (rat_done) state_d = bos_pkg::StOut;
      bos_pkg::StOut:  if (out_load) state_d = bos_pkg::StIdle;
      default:         state_d = bos_pkg::StIdle;
    endcase
  end

  assign out_load = (state_q == bos_pkg::StOut) && (!out_valid_q || m_axis_tready);

  // saturating run counter update
  always_comb begin
    if (!pass_q) begin
      run_next = '0;
    end else if (run_q == bos_pkg::RunMax) begin
      run_next = run_q;
    end else begin
      run_next = run_q + 1'b1;
    end
  end

  // control state, kept box and run counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bos_pkg::StIdle;
      pass_q      <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_w_q    <= '0;
      prev_h_q    <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == bos_pkg::StPrep) && disjoint) begin
        pass_q <= 1'b0;
      end else if ((state_q == bos_pkg::StRat) && rat_done) begin
        pass_q <= rat_pass;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        run_q       <= run_next;
        prev_x_q    <= new_x_q;
        prev_y_q    <= new_y_q;
        prev_w_q    <= new_w_q;
        prev_h_q    <= new_h_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_run_q    <= run_next;
      out_stable_q <= (run_next >= min_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_run_q, out_stable_q};

endmodule

FILE: hw/rtl/bos_checker.sv
// port-level checks of the box overlap stability check, bound to the top level
`include "box_overlap_stability_check_defines.svh"

module bos_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata
);

  // a stalled result beat holds
  `BOS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

  // one box at a time: no second beat straight after an accepted one
  `BOS_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "box accepted while another is in flight")

  // a result never appears the cycle after a box is taken
  `BOS_ASSERT(a_no_early_result, $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready), "result appeared too early")

  // nothing is offered during reset
  `BOS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "result beat offered in reset")

endmodule

bind box_overlap_stability_check bos_checker u_bos_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
